// File: rtl/cdma_pkg.sv
package cdma_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd8000;
  localparam logic [CFG_W-1:0] COOLDOWN_RST  = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_COOLDOWN  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  // Control from the sequencer to the serial accumulator.
  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctl_t;

endpackage

// File: rtl/cdma_accum.sv
module cdma_accum import cdma_pkg::*; #(
  parameter int SUM_W = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  acc_ctl_t            ctl,
  input  logic [SAMPLE_W-1:0] mag,
  output logic                done,
  output logic [SUM_W-1:0]    sum
);

  localparam int BC_W = $clog2(SUM_W);

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] mag_r, mag_nxt;
  logic                carry_r, carry_nxt;
  logic                busy_r, busy_nxt;
  logic [BC_W-1:0]     bit_r, bit_nxt;
  logic                sbit;
  logic                cout;

  // One bit of the sum per cycle; once all SUM_W bits are done the sum
  // register has rotated back into place with the magnitude added.
  assign sbit = sum_r[0] ^ mag_r[0] ^ carry_r;
  assign cout = (sum_r[0] & mag_r[0]) | (carry_r & (sum_r[0] ^ mag_r[0]));
  assign done = busy_r && (bit_r == BC_W'(SUM_W - 1));
  assign sum  = sum_r;

  always_comb begin
    sum_nxt   = sum_r;
    mag_nxt   = mag_r;
    carry_nxt = carry_r;
    busy_nxt  = busy_r;
    bit_nxt   = bit_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (busy_r) begin
      sum_nxt   = {sbit, sum_r[SUM_W-1:1]};
      mag_nxt   = {1'b0, mag_r[SAMPLE_W-1:1]};
      carry_nxt = cout;
      bit_nxt   = bit_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
    if (ctl.start) begin
      mag_nxt   = mag;
      carry_nxt = 1'b0;
      bit_nxt   = '0;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      sum_r  <= sum_nxt;
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
    end
    mag_r   <= mag_nxt;
    carry_r <= carry_nxt;
  end

endmodule

// File: rtl/cdma_div.sv
module cdma_div #(
  parameter int SUM_W = 24,
  parameter int CNT_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int BC_W = $clog2(SUM_W);

  logic [SUM_W-1:0] dq_r, dq_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             busy_r, busy_nxt;
  logic [BC_W-1:0]  bit_r, bit_nxt;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // at the top while quotient bits shift in at the bottom.
  assign trial    = {rem_r, dq_r[SUM_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = trial >= {1'b0, divisor};
  assign done     = busy_r && (bit_r == BC_W'(SUM_W - 1));
  assign quotient = dq_r;

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      bit_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      bit_nxt = bit_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// File: rtl/clap_detector_mean_abs_core.sv
// Clap detector by mean absolute amplitude.
// Input channel (in_valid/in_ready): an item is either a one-millisecond tick
// (in_opcode = 1) or an audio sample with a frame-end mark. A tick leaves
// in_ready high. A sample is added bit-serially into the frame sum, and
// in_ready stays low while it is added, so no new item is taken until the
// sum is done. The last sample of a frame then runs a one-bit-per-cycle
// restoring divider; its item passes through ST_LOAD, ST_DIV and ST_DONE
// into the output register.
// Output channel (out_valid/out_ready): mean amplitude and clap flag, one item
// per enabled frame, held in an output register. Input items keep flowing
// while a result waits; a finished frame stalls only if the previous result
// has not been taken yet.
// Configuration (cfg_valid/cfg_ready): always ready; index 0 enable,
// 1 threshold, 2 cooldown in ms. Write only while the block is idle.
// Reset (rst_n, synchronous): disabled, threshold 8000, cooldown 500 ms, frame
// sum, count and elapsed time cleared, output empty.
module clap_detector_mean_abs_core import cdma_pkg::*; #(
  parameter int FRAME_MAX = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_frame_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SAMPLE_W-1:0]        out_amplitude,
  output logic                       out_clap,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int CNT_W = $clog2(FRAME_MAX + 1);
  localparam int SUM_W = $clog2(FRAME_MAX * 32768 + 1);

  state_t              state_r, state_nxt;
  logic                enable_r, enable_nxt;
  logic [CFG_W-1:0]    thr_r, thr_nxt;
  logic [CFG_W-1:0]    cool_r, cool_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CFG_W-1:0]    elapsed_r, elapsed_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_amp_r, out_amp_nxt;
  logic                out_clap_r, out_clap_nxt;

  logic                accept;
  logic [SAMPLE_W-1:0] mag;
  acc_ctl_t            acc_ctl;
  logic                acc_done;
  logic [SUM_W-1:0]    acc_sum;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;
  logic [SAMPLE_W-1:0] amp;
  logic                clap;

  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_amplitude = out_amp_r;
  assign out_clap      = out_clap_r;

  // Full-scale negative maps to 0x8000, which still fits unsigned.
  assign mag  = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
  assign amp  = quotient[SAMPLE_W-1:0];
  assign clap = (amp > thr_r) && (elapsed_r > cool_r);

  cdma_accum #(.SUM_W(SUM_W)) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .mag   (mag),
    .done  (acc_done),
    .sum   (acc_sum)
  );

  cdma_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = enable_r;
    thr_nxt       = thr_r;
    cool_nxt      = cool_r;
    count_nxt     = count_r;
    elapsed_nxt   = elapsed_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_amp_nxt   = out_amp_r;
    out_clap_nxt  = out_clap_r;
    acc_ctl       = '0;
    div_start     = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    enable_nxt = cfg_data[0];
        CFG_THRESHOLD: thr_nxt    = cfg_data;
        CFG_COOLDOWN:  cool_nxt   = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_t'(in_opcode) == OP_TICK) begin
            if (elapsed_r != '1) begin
              elapsed_nxt = elapsed_r + 1'b1;
            end
          end else if (!enable_r) begin
            acc_ctl.clear = 1'b1;
            count_nxt     = '0;
          end else begin
            pend_last_nxt = in_frame_last;
            if (count_r < CNT_W'(FRAME_MAX)) begin
              acc_ctl.start = 1'b1;
              count_nxt     = count_r + 1'b1;
              state_nxt     = ST_ADD;
            end else if (in_frame_last) begin
              // A full frame ignores the sample but still closes on the mark.
              state_nxt = ST_LOAD;
            end
          end
        end
      end
      ST_ADD: begin
        if (acc_done) begin
          state_nxt = pend_last_r ? ST_LOAD : ST_IDLE;
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_amp_nxt   = amp;
          out_clap_nxt  = clap;
          if (clap) begin
            elapsed_nxt = '0;
          end
          acc_ctl.clear = 1'b1;
          count_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      thr_r       <= THRESHOLD_RST;
      cool_r      <= COOLDOWN_RST;
      count_r     <= '0;
      elapsed_r   <= '0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      thr_r       <= thr_nxt;
      cool_r      <= cool_nxt;
      count_r     <= count_nxt;
      elapsed_r   <= elapsed_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_amp_r  <= out_amp_nxt;
    out_clap_r <= out_clap_nxt;
  end

endmodule

// File: rtl/cdma_checker.sv
module cdma_checker import cdma_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_opcode,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_amplitude,
  input logic                out_clap,
  input logic                cfg_ready
);

  // A waiting result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_amplitude) && $stable(out_clap))
    else $error("output item changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A tick is handled without leaving the idle state, so the input stays open after it.
  a_tick_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (opcode_t'(in_opcode) == OP_TICK) |=> in_ready)
    else $error("input closed after a tick item");

  // A clap needs an amplitude strictly above a non-negative threshold.
  a_clap_amp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clap |-> out_amplitude != '0)
    else $error("clap flagged with zero amplitude");

  // Configuration writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready && $past(cfg_ready))
    else $error("configuration port stalled");

endmodule

bind clap_detector_mean_abs_core cdma_checker u_cdma_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_opcode     (in_opcode),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_amplitude (out_amplitude),
  .out_clap      (out_clap),
  .cfg_ready     (cfg_ready)
);
